[sv/ccr_pkg.sv]
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the clock controller registers
// Register map indexes, reset words, datapath widths and the command record
// that travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package ccr_pkg;

  // register bank geometry
  localparam int REG_WORDS = 64;
  localparam int AW        = $clog2(REG_WORDS);
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;

  // clock datapath widths
  localparam int REF_W     = 27;
  localparam int MDIV_W    = 10;
  localparam int PCLK_W    = 37;
  localparam int NUM_W     = REF_W + MDIV_W;
  localparam int DEN_W     = 19;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int HP_W      = 6;
  localparam int EDIV_W    = 4;

  // stream widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 72;

  // opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register indexes
  localparam int IDX_LOCKCON0 = 0;
  localparam int IDX_LOCKCON1 = 1;
  localparam int IDX_OSCSET   = 2;
  localparam int IDX_MPLLCON  = 4;
  localparam int IDX_EPLLCON  = 6;
  localparam int IDX_EPLL_FRAC = 7;
  localparam int IDX_CLKSRC   = 8;
  localparam int IDX_CLKDIV0  = 9;
  localparam int IDX_CLKDIV1  = 10;
  localparam int IDX_CLKDIV2  = 11;
  localparam int IDX_HCLKCON  = 12;
  localparam int IDX_PCLKCON  = 13;
  localparam int IDX_SCLKCON  = 14;

  // reset words
  localparam logic [DATA_W-1:0] RST_LOCKCON = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] RST_OSCSET  = 32'h0000_8000;
  localparam logic [DATA_W-1:0] RST_MPLLCON = 32'h0064_0062;
  localparam logic [DATA_W-1:0] RST_EPLLCON = 32'h0020_0103;
  localparam logic [DATA_W-1:0] RST_CLKSRC  = 32'h0000_0010;
  localparam logic [DATA_W-1:0] RST_CLKDIV0 = 32'h0000_002c;
  localparam logic [DATA_W-1:0] RST_HCLKCON = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] RST_SCLKCON = 32'hffff_dfff;

  localparam logic [REF_W-1:0]  RST_REF_HZ  = 27'd12000000;
  localparam logic [PCLK_W-1:0] RST_PCLK_HZ = 37'd66666666;

  // PCLKCON timer enable bit
  localparam int TIMER_BIT = 10;

  // classified bus command
  typedef struct packed {
    logic              write;
    logic              in_range;
    logic              clock_word;
    logic              pclkcon;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } cmd_t;

  // word a bank entry holds until it is first written
  function automatic logic [DATA_W-1:0] reset_word(input logic [AW-1:0] a);
    logic [DATA_W-1:0] w;
    w = '0;
    if (a == AW'(IDX_LOCKCON0) || a == AW'(IDX_LOCKCON1)) w = RST_LOCKCON;
    else if (a == AW'(IDX_OSCSET))  w = RST_OSCSET;
    else if (a == AW'(IDX_MPLLCON)) w = RST_MPLLCON;
    else if (a == AW'(IDX_EPLLCON)) w = RST_EPLLCON;
    else if (a == AW'(IDX_CLKSRC))  w = RST_CLKSRC;
    else if (a == AW'(IDX_CLKDIV0)) w = RST_CLKDIV0;
    else if (a == AW'(IDX_HCLKCON)) w = RST_HCLKCON;
    else if (a == AW'(IDX_SCLKCON)) w = RST_SCLKCON;
    return w;
  endfunction

endpackage

[sv/ccr_front.sv]
// ----------------------------------------------------------------------------
// ccr_front: bus command front end
// Unpacks a slave-side transfer, decodes the register index and pushes the
// classified command into the queue.
// ----------------------------------------------------------------------------
module ccr_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ccr_pkg::S_TDATA_W-1:0] s_tdata,   // word_index, write_data
  input  logic                          s_tuser,   // opcode
  input  logic                          q_full,
  output logic                          q_push,
  output ccr_pkg::cmd_t                 q_cmd
);
  import ccr_pkg::*;

  logic [IDX_W-1:0] idx;

  assign idx      = s_tdata[IDX_W-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // decode the index into its register class
  always_comb begin
    q_cmd            = '0;
    q_cmd.write      = (s_tuser == OP_WRITE);
    q_cmd.idx        = idx;
    q_cmd.data       = s_tdata[IDX_W +: DATA_W];
    q_cmd.in_range   = ({1'b0, idx} < (IDX_W+1)'(REG_WORDS));
    q_cmd.pclkcon    = (idx == IDX_W'(IDX_PCLKCON));
    q_cmd.clock_word = (idx == IDX_W'(IDX_MPLLCON))   || (idx == IDX_W'(IDX_EPLLCON)) ||
                       (idx == IDX_W'(IDX_EPLL_FRAC)) || (idx == IDX_W'(IDX_CLKSRC))  ||
                       (idx == IDX_W'(IDX_CLKDIV0))   || (idx == IDX_W'(IDX_CLKDIV1)) ||
                       (idx == IDX_W'(IDX_CLKDIV2));
  end

endmodule

[sv/ccr_queue.sv]
// ----------------------------------------------------------------------------
// ccr_queue: two-entry command queue
// Holds classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module ccr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ccr_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import ccr_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

[sv/ccr_div.sv]
// ----------------------------------------------------------------------------
// ccr_div: bit-serial restoring divider
// Divides the clock numerator by the combined divisor, one quotient bit
// per cycle, and pulses done with the quotient.
// ----------------------------------------------------------------------------
module ccr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ccr_pkg::NUM_W-1:0] num,
  input  logic [ccr_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [ccr_pkg::NUM_W-1:0] quot
);
  import ccr_pkg::*;

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift in the next numerator bit and try the subtraction
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && !start && (steps == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quot  <= num;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

[sv/ccr_back.sv]
// ----------------------------------------------------------------------------
// ccr_back: register bank and clock recompute engine
// Pops commands, reads and writes the word bank, tracks the timer enable,
// recomputes the peripheral clock and loads the master-side result register.
// ----------------------------------------------------------------------------
module ccr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ccr_pkg::REF_W-1:0]     ref_hz,
  input  ccr_pkg::cmd_t                 head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ccr_pkg::M_TDATA_W-1:0] m_tdata
);
  import ccr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DEN  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]           state;
  cmd_t                 cmd;
  logic [DATA_W-1:0]    mem [REG_WORDS];
  logic [REG_WORDS-1:0] written;
  logic [DATA_W-1:0]    mem_q;
  logic                 mem_q_ok;
  logic [DATA_W-1:0]    old_word;
  logic [AW-1:0]        addr;
  logic                 bank_we;
  logic                 out_load;

  logic [DATA_W-1:0]    mpllcon;
  logic [DATA_W-1:0]    clksrc;
  logic [DATA_W-1:0]    clkdiv0;
  logic [PCLK_W-1:0]    pclk;
  logic                 timer_on;
  logic                 fault;
  logic [DATA_W-1:0]    rd_word;

  logic [NUM_W-1:0]     num;
  logic [HP_W-1:0]      hp;
  logic [EDIV_W-1:0]    ediv;
  logic [DEN_W-1:0]     den;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     quot;

  logic [MDIV_W-1:0]    mdiv;
  logic [5:0]           pdiv;
  logic [2:0]           sdiv;
  logic                 pll_sel;
  logic                 pll_zero;

  // clock chain fields
  assign mdiv     = mpllcon[14 +: MDIV_W];
  assign pdiv     = mpllcon[10:5];
  assign sdiv     = mpllcon[2:0];
  assign pll_sel  = clksrc[4];
  assign pll_zero = pll_sel && (pdiv == 6'd0);

  assign addr     = cmd.idx[AW-1:0];
  assign old_word = mem_q_ok ? mem_q : reset_word(addr);
  assign pop      = (state == ST_IDLE) && !empty;
  assign bank_we  = (state == ST_LOOK) && cmd.write && cmd.in_range;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // combined divisor: predivider shifted, external divider, hclk and pclk
  always_comb begin
    if (pll_sel) den = DEN_W'({12'(pdiv * hp), 7'd0} >> (3'd7 - sdiv));
    else         den = DEN_W'(ediv * hp);
  end

  assign div_start = (state == ST_DEN) && !pll_zero;

  ccr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // word bank with registered read
  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q <= mem[head.idx[AW-1:0]];
    end
    if (bank_we) begin
      mem[addr] <= cmd.data;
    end
  end

  // first-write marks and read-side mark
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      mem_q_ok <= 1'b0;
    end else begin
      if (pop)     mem_q_ok <= written[head.idx[AW-1:0]];
      if (bank_we) written[addr] <= 1'b1;
    end
  end

  // sequencer, status and shadow clock words
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mpllcon  <= RST_MPLLCON;
      clksrc   <= RST_CLKSRC;
      clkdiv0  <= RST_CLKDIV0;
      pclk     <= RST_PCLK_HZ;
      timer_on <= 1'b0;
      fault    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load)                  m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) state <= ST_LOOK;
        end
        ST_LOOK: begin
          if (bank_we) begin
            if (cmd.pclkcon) timer_on <= cmd.data[TIMER_BIT];
            if (cmd.idx == IDX_W'(IDX_MPLLCON)) mpllcon <= cmd.data;
            if (cmd.idx == IDX_W'(IDX_CLKSRC))  clksrc  <= cmd.data;
            if (cmd.idx == IDX_W'(IDX_CLKDIV0)) clkdiv0 <= cmd.data;
          end
          if (bank_we && cmd.clock_word && (cmd.data != old_word)) state <= ST_MUL;
          else                                                     state <= ST_DONE;
        end
        ST_MUL: begin
          fault <= (pdiv == 6'd0);
          state <= ST_DEN;
        end
        ST_DEN: begin
          if (pll_zero) begin
            pclk  <= '0;
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            pclk  <= PCLK_W'(quot);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command capture, read word and recompute operands
  always_ff @(posedge clk) begin
    if (pop) cmd <= head;
    if (state == ST_LOOK) begin
      rd_word <= (!cmd.write && cmd.in_range) ? old_word : '0;
    end
    if (state == ST_MUL) begin
      num  <= pll_sel ? (NUM_W'(ref_hz) * NUM_W'(mdiv)) : NUM_W'(ref_hz);
      hp   <= HP_W'((3'({1'b0, clkdiv0[5:4]}) + 3'd1) * (3'({1'b0, clkdiv0[1:0]}) + 3'd1))
              << clkdiv0[2];
      ediv <= clksrc[3] ? EDIV_W'({clkdiv0[8:6], 1'b1}) : EDIV_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, fault, timer_on, pclk, rd_word};
    end
  end

endmodule

[sv/clock_controller_registers.sv]
// ----------------------------------------------------------------------------
// clock_controller_registers: clock controller register bank
// Bank of 32-bit words with PLL and divider based peripheral clock tracking.
// ----------------------------------------------------------------------------
// Each slave-side transfer is one register access (tuser 0 read, 1 write) and
// returns exactly one master-side result with the read word (zero on writes),
// the current peripheral clock in hertz, the timer enable and the divide
// fault. Accesses are carried out one at a time. A read, or a write that does
// not change the clock, goes from the look-up state straight to the done
// state. A write that changes MPLLCON, EPLLCON, the EPLL fraction word, CLKSRC
// or CLKDIV0/1/2 recomputes the clock through the multiply, divisor and
// divide states; the bit-serial divider produces one bit of the 37-bit
// quotient per cycle. With the PLL selected and a zero predivider the divide
// is skipped. A two-entry queue sits between the input decode and the bank
// engine, and the result is held in an output register, so up to three
// further accesses are taken while a result waits. ref_clock_hz is written
// through cfg_we/cfg_wdata and takes effect at the next recompute.
module clock_controller_registers (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ccr_pkg::REF_W-1:0]     cfg_wdata,  // ref_clock_hz
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ccr_pkg::S_TDATA_W-1:0] s_tdata,    // word_index[5:0], write_data[37:6]
  input  logic                          s_tuser,    // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ccr_pkg::M_TDATA_W-1:0] m_tdata     // read_data[31:0], pclk_hz[68:32],
                                                    // timer_enable[69], divide_fault[70]
);
  import ccr_pkg::*;

  logic [REF_W-1:0] ref_hz;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  cmd_t             q_in;
  cmd_t             q_head;

  // reference clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_hz <= RST_REF_HZ;
    end else if (cfg_we) begin
      ref_hz <= cfg_wdata;
    end
  end

  ccr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  ccr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ccr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ref_hz   (ref_hz),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: clock controller register bank
// Drives register reads and writes over the slave stream and checks every
// result transfer field by field against a typed row or a cycle-free predictor
// of the bank, the clock chain divide and the timer/fault flags. A directed
// table runs first, then random accesses under several reference clocks.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ccr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int CHUNK_ITEMS   = 232;
  localparam int DRAIN_CYCLES  = 60;
  localparam int NUM_DIRECTED  = 25;

  // one expected result transfer
  typedef struct packed {
    logic [31:0] rd;
    logic [36:0] pclk;
    logic        tmr;
    logic        flt;
  } access_result_t;

  // one row of the directed table; typed marks a hand-written expectation
  typedef struct packed {
    logic        op;
    logic [5:0]  idx;
    logic [31:0] data;
    logic        typed;
    logic [31:0] rd;
    logic [36:0] pclk;
    logic        tmr;
    logic        flt;
  } access_row_t;

  localparam access_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset contents
    '{OP_READ,  6'(IDX_LOCKCON0), 32'h0, 1'b1, 32'h0000ffff, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_OSCSET),   32'h0, 1'b1, 32'h00008000, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_MPLLCON),  32'h0, 1'b1, 32'h00640062, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_CLKDIV0),  32'h0, 1'b1, 32'h0000002c, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_HCLKCON),  32'h0, 1'b1, 32'hffffffff, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_SCLKCON),  32'h0, 1'b1, 32'hffffdfff, 37'd66666666, 1'b0, 1'b0},
    '{OP_READ,  6'd63,            32'hffffffff, 1'b1, 32'h0, 37'd66666666, 1'b0, 1'b0},
    // timer enable on
    '{OP_WRITE, 6'(IDX_PCLKCON),  32'h400, 1'b1, 32'h0, 37'd66666666, 1'b1, 1'b0},
    '{OP_READ,  6'(IDX_PCLKCON),  32'h0, 1'b1, 32'h400, 37'd66666666, 1'b1, 1'b0},
    // zero predivider with the pll selected
    '{OP_WRITE, 6'(IDX_MPLLCON),  32'h00640002, 1'b1, 32'h0, 37'd0, 1'b1, 1'b1},
    // unchanged clock word, then back to the reset pll
    '{OP_WRITE, 6'(IDX_MPLLCON),  32'h00640002, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_MPLLCON),  32'h00640062, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    // external divider path and divider extremes
    '{OP_WRITE, 6'(IDX_CLKSRC),   32'h00000008, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_CLKDIV0),  32'hffffffff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_CLKDIV0),  32'h00000000, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_EPLLCON),  32'hffffffff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_EPLL_FRAC), 32'ha5a5a5a5, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_CLKDIV1),  32'h5a5a5a5a, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_CLKDIV2),  32'hffffffff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_CLKSRC),   32'h00000010, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_MPLLCON),  32'hffffffff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    // plain storage at the top of the bank
    '{OP_WRITE, 6'd63,            32'hffffffff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_READ,  6'd63,            32'h0, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_WRITE, 6'(IDX_PCLKCON),  32'hfffffbff, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0},
    '{OP_READ,  6'(IDX_EPLL_FRAC), 32'h0, 1'b0, 32'h0, 37'd0, 1'b0, 1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [REF_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;    // word_index[5:0], write_data[37:6]
  logic                   s_tuser;    // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;    // read_data[31:0], pclk_hz[68:32],
                                      // timer_enable[69], divide_fault[70]

  // predicted bank state
  logic [31:0]            bank_words [64];
  logic [26:0]            ref_hz;
  logic [36:0]            pclk_now;
  logic                   timer_now;
  logic                   fault_now;

  access_result_t         pending_results [$];
  access_result_t         want_res;
  int                     tx_idle_pct;
  int                     rx_idle_pct;
  int                     error_count;
  int                     accepted_count;
  int                     result_count;
  int                     recompute_count;
  int                     fault_count;
  int                     cycle_count;

  clock_controller_registers dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // clock chain: pll or reference, then prescaler, hclk and pclk dividers
  function automatic void recompute_pclk();
    logic [31:0]     mpll_word;
    logic [31:0]     src_word;
    logic [31:0]     div_word;
    longint unsigned refv;
    longint unsigned mdiv;
    longint unsigned pdiv;
    longint unsigned sdiv;
    longint unsigned pll_hz;
    longint unsigned direct_hz;
    longint unsigned sys_hz;
    longint unsigned hclk_hz;
    longint unsigned pre_div;
    longint unsigned hclk_div;
    longint unsigned pclk_div;
    longint unsigned ext_div;
    mpll_word = bank_words[IDX_MPLLCON];
    src_word  = bank_words[IDX_CLKSRC];
    div_word  = bank_words[IDX_CLKDIV0];
    refv = longint'(ref_hz);
    mdiv = longint'(mpll_word[23:14]);
    pdiv = longint'(mpll_word[10:5]);
    sdiv = longint'(mpll_word[2:0]);
    if (pdiv == 0) begin
      pll_hz    = 0;
      fault_now = 1'b1;
    end else begin
      pll_hz    = (refv * mdiv) / (pdiv << sdiv);
      fault_now = 1'b0;
    end
    ext_div   = 2 * longint'(div_word[8:6]) + 1;
    direct_hz = src_word[3] ? refv / ext_div : refv;
    sys_hz    = src_word[4] ? pll_hz : direct_hz;
    pre_div   = longint'(div_word[5:4]) + 1;
    hclk_div  = longint'(div_word[1:0]) + 1;
    pclk_div  = longint'(div_word[2]) + 1;
    hclk_hz   = sys_hz / (pre_div * hclk_div);
    pclk_now  = 37'(hclk_hz / pclk_div);
    recompute_count++;
    if (fault_now) fault_count++;
  endfunction

  // bank reset contents
  function automatic void reset_bank();
    for (int i = 0; i < 64; i++) bank_words[i] = 32'h0;
    bank_words[IDX_LOCKCON0] = 32'h0000ffff;
    bank_words[IDX_LOCKCON1] = 32'h0000ffff;
    bank_words[IDX_OSCSET]   = 32'h00008000;
    bank_words[IDX_MPLLCON]  = 32'h00640062;
    bank_words[IDX_EPLLCON]  = 32'h00200103;
    bank_words[IDX_CLKSRC]   = 32'h00000010;
    bank_words[IDX_CLKDIV0]  = 32'h0000002c;
    bank_words[IDX_HCLKCON]  = 32'hffffffff;
    bank_words[IDX_SCLKCON]  = 32'hffffdfff;
    ref_hz    = 27'd12000000;
    timer_now = 1'b0;
    fault_now = 1'b0;
    recompute_pclk();
  endfunction

  // one register access against the predicted bank
  function automatic access_result_t predict_access(input logic op, input logic [5:0] idx,
                                                    input logic [31:0] data);
    access_result_t res;
    logic           clock_change;
    res.rd = 32'h0;
    clock_change = 1'b0;
    if (int'(idx) < REG_WORDS) begin
      if (op == OP_READ) begin
        res.rd = bank_words[idx];
      end else begin
        case (int'(idx))
          IDX_MPLLCON, IDX_EPLLCON, IDX_EPLL_FRAC, IDX_CLKSRC,
          IDX_CLKDIV0, IDX_CLKDIV1, IDX_CLKDIV2: begin
            clock_change = (data != bank_words[idx]);
          end
          IDX_PCLKCON: begin
            timer_now = data[TIMER_BIT];
          end
          default: ;
        endcase
        bank_words[idx] = data;
        if (clock_change) recompute_pclk();
      end
    end
    res.pclk = pclk_now;
    res.tmr  = timer_now;
    res.flt  = fault_now;
    return res;
  endfunction

  // one slave-side transfer, with random sender gaps ahead of it
  task automatic issue_access(input logic op, input logic [5:0] idx, input logic [31:0] data,
                              input logic use_typed, input access_result_t typed_res);
    access_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, data, idx};
    do @(posedge clk); while (!s_tready);
    predicted = predict_access(op, idx, data);
    pending_results.push_back(use_typed ? typed_res : predicted);
    accepted_count++;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reference clock write while the bank is idle
  task automatic write_ref_clock(input logic [REF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ref_hz    = value;
  endtask

  // random access: mostly clock words and reads, some storage and timer writes
  task automatic random_access();
    logic        op;
    logic [5:0]  idx;
    logic [31:0] data;
    int          pick;
    access_result_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    data = $urandom;
    if (pick < 35) begin
      op  = OP_READ;
      idx = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
    end else if (pick < 65) begin
      op = OP_WRITE;
      case ($urandom_range(0, 6))
        0: idx = 6'(IDX_MPLLCON);
        1: idx = 6'(IDX_EPLLCON);
        2: idx = 6'(IDX_EPLL_FRAC);
        3: idx = 6'(IDX_CLKSRC);
        4: idx = 6'(IDX_CLKDIV0);
        5: idx = 6'(IDX_CLKDIV1);
        default: idx = 6'(IDX_CLKDIV2);
      endcase
      // keep the pll sensible half the time so pclk stays nonzero
      if (int'(idx) == IDX_MPLLCON && $urandom_range(0, 1) == 1) begin
        data[10:5] = 6'($urandom_range(1, 3));
        data[2:0]  = 3'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 4) == 0) data = bank_words[idx];
    end else if (pick < 75) begin
      op  = OP_WRITE;
      idx = 6'(IDX_PCLKCON);
    end else begin
      op  = OP_WRITE;
      idx = 6'($urandom_range(0, 63));
    end
    issue_access(op, idx, data, 1'b0, none);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result transfers checked in order against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transfer, actual %0h", $time, m_tdata);
      end else begin
        want_res = pending_results.pop_front();
        check_field("read_data",    64'(want_res.rd),   64'(m_tdata[31:0]));
        check_field("pclk_hz",      64'(want_res.pclk), 64'(m_tdata[68:32]));
        check_field("timer_enable", 64'(want_res.tmr),  64'(m_tdata[69]));
        check_field("divide_fault", 64'(want_res.flt),  64'(m_tdata[70]));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    access_result_t row_res;
    access_row_t    row;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    s_tvalid        = 1'b0;
    s_tuser         = 1'b0;
    s_tdata         = '0;
    tx_idle_pct     = 21;
    rx_idle_pct     = 57;
    error_count     = 0;
    accepted_count  = 0;
    result_count    = 0;
    recompute_count = 0;
    fault_count     = 0;
    cycle_count     = 0;
    reset_bank();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_ref_clock(27'd12000000);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row          = DIRECTED_ROWS[i];
      row_res.rd   = row.rd;
      row_res.pclk = row.pclk;
      row_res.tmr  = row.tmr;
      row_res.flt  = row.flt;
      issue_access(row.op, row.idx, row.data, row.typed, row_res);
    end

    // random chunks under 100 MHz, 1 Hz, zero and random reference clocks
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_idle();
      case (chunk)
        0: write_ref_clock(27'd100000000);
        1: write_ref_clock(27'd1);
        2: write_ref_clock(27'd0);
        default: write_ref_clock(27'($urandom_range(1, 100000000)));
      endcase
      if (chunk == 1) begin
        tx_idle_pct = 57;
        rx_idle_pct = 21;
      end else if (chunk >= 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        if (n == 100 || $urandom_range(0, 49) == 0) wait_idle();
        random_access();
      end
    end

    // drain
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses and %0d results, %0d clock recomputes (%0d with zero pdiv)",
             accepted_count, result_count, recompute_count, fault_count);
    $display("reference clocks 12 MHz, max, 1 Hz, zero and random; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[clock_controller_registers.f]
sv/ccr_pkg.sv
sv/ccr_front.sv
sv/ccr_queue.sv
sv/ccr_div.sv
sv/ccr_back.sv
sv/clock_controller_registers.sv
verif/testbench.sv
